FILE: rtl/core/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly table package
// Shared types, constants and codes for the fragment reassembly table.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int SLOT_COUNT     = 16;
	localparam int SLOT_BYTES     = 1024;
	localparam int WORDS_PER_SLOT = (SLOT_BYTES + 7) / 8;
	localparam int STORE_WORDS    = SLOT_COUNT * WORDS_PER_SLOT;
	localparam int SLOT_W         = 4;
	localparam int WORD_W         = $clog2(WORDS_PER_SLOT);
	localparam int ADDR_W         = $clog2(STORE_WORDS);
	localparam int CNT_W          = $clog2(SLOT_COUNT + 1);
	localparam int PIECE_W        = 13;
	localparam int LEN_W          = 17;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	localparam logic [1:0] OP_HEADER  = 2'd0;
	localparam logic [1:0] OP_PAYLOAD = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	localparam logic [2:0] ST_ACCEPT   = 3'd0;
	localparam logic [2:0] ST_REJECT   = 3'd1;
	localparam logic [2:0] ST_COMPLETE = 3'd2;
	localparam logic [2:0] ST_READ     = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] peer_gen;
		logic [15:0] peer_num;
		logic [63:0] msg_seq;
		logic [11:0] frag_bytes;
		logic [7:0]  frag_index;
		logic [7:0]  frag_total;
		logic [8:0]  word_index;
		logic [63:0] data_word;
		logic        last_word;
		logic [3:0]  slot_sel;
	} frt_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot_out;
		logic [16:0] message_bytes;
		logic [63:0] read_word;
	} frt_out_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SCAN,
		CMD_HDR_NEW,
		CMD_HDR_OLD,
		CMD_WRITE,
		CMD_WALK_INIT,
		CMD_WALK,
		CMD_CLEAR,
		CMD_RESP,
		CMD_EVICT,
		CMD_REJECT
	} frt_cmd_t;

	typedef struct packed {
		logic hdr_ok;
		logic scan_done;
		logic found;
		logic match_ok;
		logic new_ok;
		logic evict_done;
		logic pay_ok;
		logic last;
		logic walk_done;
		logic read_ok;
		logic clear_ok;
	} frt_stat_t;

endpackage

FILE: rtl/core/fragment_reassembly_table_unit.sv
// ----------------------------------------------------------------------------
// Fragment reassembly table
// Reassembles message fragments into a ring of 16 slots of 1024 bytes.
//
// channel  ports                      transfer
// in       start, busy, in_item       start & !busy
// out      valid, out_item            valid (one cycle, no stall)
//
// A header scans the slots for its owner and evicts the slots of a new run;
// a malformed header is rejected without a scan. The last payload word
// of a fragment also walks the run. Reset empties the span, piece and
// total tables of every slot at once.
// The result strobe lasts one cycle; busy stays high until it is shown.
// ----------------------------------------------------------------------------
module fragment_reassembly_table_unit import frt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  frt_in_t  in_item,
	output logic     valid,
	output frt_out_t out_item
);

	frt_cmd_t  cmd;
	frt_stat_t stat;
	frt_out_t  rsp;
	logic      done, rej;
	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) op_q <= OP_HEADER;
		else if (start && !busy) op_q <= in_item.op;
	end

	frt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op_q), .stat(stat),
		.cmd(cmd), .busy(busy), .done(done), .rej(rej)
	);

	frt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_item), .stat(stat), .rsp(rsp)
	);

	logic rej_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rej_q <= 1'b0;
		else if (rej) rej_q <= 1'b1;
		else if (done) rej_q <= 1'b0;
	end

	assign valid = done;
	assign out_item = rej_q ? frt_out_t'{ST_REJECT, 4'd0, 17'd0, 64'd0} : rsp;

endmodule

FILE: rtl/core/frt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single-port write, single read port with registered read data.
// ----------------------------------------------------------------------------
module frt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/frt_datapath.sv
// ----------------------------------------------------------------------------
// Fragment reassembly datapath
// Slot tables, owner scan, run walk and payload store.
// ----------------------------------------------------------------------------
module frt_datapath import frt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  frt_cmd_t  cmd,
	input  frt_in_t   in_item,
	output frt_stat_t stat,
	output frt_out_t  rsp
);

	frt_in_t             it_q;
	logic [7:0]          span_q  [SLOT_COUNT];
	logic [31:0]         gen_q   [SLOT_COUNT];
	logic [15:0]         peer_q  [SLOT_COUNT];
	logic [63:0]         seq_q   [SLOT_COUNT];
	logic [PIECE_W-1:0]  piece_q [SLOT_COUNT];
	logic [LEN_W-1:0]    total_q [SLOT_COUNT];
	logic [CNT_W-1:0]    next_free_q;
	logic [SLOT_W-1:0]   p_head_q, p_target_q;
	logic                p_valid_q;
	logic [CNT_W-1:0]    idx_q;
	logic [SLOT_W-1:0]   head_q;
	logic                found_q;
	logic [7:0]          ecnt_q;
	logic [LEN_W+1:0]    len_q;
	logic                bad_q;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
	logic [63:0]         ram_rdata;
	logic [SLOT_W-1:0]   scan_slot, walk_slot, new_head;
	logic [8:0]          tgt_sum;
	logic [7:0]          span_h;
	logic [CNT_W:0]      run_end;
	logic [LEN_W+1:0]    len_sat_in;

	assign scan_slot = idx_q[SLOT_W-1:0];
	assign span_h    = span_q[p_head_q];
	assign walk_slot = p_head_q + idx_q[SLOT_W-1:0];
	assign tgt_sum   = {5'd0, head_q} + {1'b0, it_q.frag_index};
	assign new_head  = ({1'b0, 8'(SLOT_COUNT) - {{(8-CNT_W){1'b0}}, next_free_q}}
		>= {1'b0, it_q.frag_total}) ? next_free_q[SLOT_W-1:0] : '0;
	assign run_end   = {{(CNT_W+1-SLOT_W){1'b0}}, p_head_q} + (CNT_W+1)'(span_h);

	always_comb begin
		stat = '0;
		stat.hdr_ok = (it_q.frag_total != 0) && (it_q.frag_index < it_q.frag_total)
			&& (it_q.frag_bytes != 0) && ({1'b0, it_q.frag_bytes} <= 13'(SLOT_BYTES))
			&& ((13'({1'b0, it_q.frag_bytes}) == 13'(SLOT_BYTES))
			|| ({1'b0, it_q.frag_index} + 9'd1 == {1'b0, it_q.frag_total}));
		stat.scan_done  = (idx_q == CNT_W'(SLOT_COUNT)) || found_q;
		stat.found      = found_q;
		stat.match_ok   = (span_q[head_q] == it_q.frag_total) && (tgt_sum < 9'(SLOT_COUNT));
		stat.new_ok     = (it_q.frag_total <= 8'(SLOT_COUNT));
		stat.evict_done = (ecnt_q == it_q.frag_total);
		stat.pay_ok     = p_valid_q && (it_q.word_index < 9'(WORDS_PER_SLOT));
		stat.last       = it_q.last_word;
		stat.walk_done  = bad_q || ({1'b0, idx_q} == (CNT_W+1)'(span_h));
		stat.read_ok    = ({1'b0, it_q.slot_sel} < 5'(SLOT_COUNT))
			&& (it_q.word_index < 9'(WORDS_PER_SLOT));
		stat.clear_ok   = ({1'b0, it_q.slot_sel} < 5'(SLOT_COUNT));
	end

	assign len_sat_in = len_q + (LEN_W+2)'(piece_q[walk_slot]);

	always_comb begin
		ram_we    = (cmd == CMD_WRITE) && p_valid_q
			&& (it_q.word_index < 9'(WORDS_PER_SLOT));
		ram_waddr = ADDR_W'(p_target_q * WORDS_PER_SLOT + it_q.word_index[WORD_W-1:0]);
		ram_raddr = ADDR_W'(it_q.slot_sel * WORDS_PER_SLOT + it_q.word_index[WORD_W-1:0]);
	end

	frt_ram #(.WIDTH(64), .DEPTH(STORE_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (it_q.data_word),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			it_q <= in_item;
		end
		if (cmd == CMD_HDR_NEW) begin
			gen_q[new_head]  <= it_q.peer_gen;
			peer_q[new_head] <= it_q.peer_num;
			seq_q[new_head]  <= it_q.msg_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				span_q[i]  <= '0;
				piece_q[i] <= '0;
				total_q[i] <= '0;
			end
			next_free_q <= '0;
			p_head_q    <= '0;
			p_target_q  <= '0;
			p_valid_q   <= 1'b0;
			idx_q       <= '0;
			head_q      <= '0;
			found_q     <= 1'b0;
			ecnt_q      <= '0;
			len_q       <= '0;
			bad_q       <= 1'b0;
			rsp         <= '0;
		end else begin
			unique case (cmd)
				CMD_LOAD: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					ecnt_q  <= '0;
				end
				CMD_SCAN: begin
					if (span_q[scan_slot] != 0 && gen_q[scan_slot] == it_q.peer_gen
						&& peer_q[scan_slot] == it_q.peer_num
						&& seq_q[scan_slot] == it_q.msg_seq) begin
						found_q <= 1'b1;
						head_q  <= scan_slot;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				CMD_EVICT: begin
					span_q[new_head + ecnt_q[SLOT_W-1:0]]  <= '0;
					piece_q[new_head + ecnt_q[SLOT_W-1:0]] <= '0;
					total_q[new_head + ecnt_q[SLOT_W-1:0]] <= '0;
					ecnt_q <= ecnt_q + 1'b1;
				end
				CMD_HDR_NEW: begin
					span_q[new_head] <= it_q.frag_total;
					next_free_q <= CNT_W'({1'b0, new_head} + {1'b0, it_q.frag_total[SLOT_W:0]});
					piece_q[new_head + it_q.frag_index[SLOT_W-1:0]] <= {1'b0, it_q.frag_bytes};
					p_head_q   <= new_head;
					p_target_q <= new_head + it_q.frag_index[SLOT_W-1:0];
					p_valid_q  <= 1'b1;
					rsp <= '{ST_ACCEPT, new_head, '0, '0};
				end
				CMD_HDR_OLD: begin
					piece_q[tgt_sum[SLOT_W-1:0]] <= {1'b0, it_q.frag_bytes};
					p_head_q   <= head_q;
					p_target_q <= tgt_sum[SLOT_W-1:0];
					p_valid_q  <= 1'b1;
					rsp <= '{ST_ACCEPT, head_q, '0, '0};
				end
				CMD_WRITE: begin
					if (!p_valid_q || it_q.word_index >= 9'(WORDS_PER_SLOT)) begin
						rsp <= '{ST_REJECT, '0, '0, '0};
						if (it_q.op == OP_HEADER) p_valid_q <= 1'b0;
					end else begin
						rsp <= '{ST_ACCEPT, p_head_q, '0, '0};
					end
				end
				CMD_WALK_INIT: begin
					p_valid_q <= 1'b0;
					idx_q <= '0;
					len_q <= '0;
					bad_q <= (span_h == 0) || (run_end > (CNT_W+1)'(SLOT_COUNT));
				end
				CMD_WALK: begin
					if ({1'b0, idx_q} + 1'b1 == (CNT_W+1)'(span_h)) begin
						if (piece_q[walk_slot] == 0) bad_q <= 1'b1;
					end else if (piece_q[walk_slot] != 13'(SLOT_BYTES)) begin
						bad_q <= 1'b1;
					end
					len_q <= len_sat_in;
					idx_q <= idx_q + 1'b1;
				end
				CMD_CLEAR: begin
					if (it_q.op == OP_CLEAR) begin
						span_q[it_q.slot_sel]  <= '0;
						piece_q[it_q.slot_sel] <= '0;
						total_q[it_q.slot_sel] <= '0;
						rsp <= '{ST_CLEARED, it_q.slot_sel, '0, '0};
					end else if (bad_q) begin
						rsp <= '{ST_ACCEPT, p_head_q, '0, '0};
					end else begin
						total_q[p_head_q] <= (len_q > (LEN_W+2)'(LEN_MAX)) ? LEN_MAX
							: len_q[LEN_W-1:0];
						rsp <= '{ST_COMPLETE, p_head_q,
							(len_q > (LEN_W+2)'(LEN_MAX)) ? LEN_MAX : len_q[LEN_W-1:0], '0};
					end
				end
				CMD_RESP: begin
					rsp <= '{ST_READ, it_q.slot_sel, '0, ram_rdata};
				end
				CMD_REJECT: begin
					if (it_q.op == OP_HEADER) p_valid_q <= 1'b0;
					rsp <= '{ST_REJECT, '0, '0, '0};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/frt_ctrl.sv
// ----------------------------------------------------------------------------
// Fragment reassembly controller
// Sequences header, payload, read and clear transactions.
// ----------------------------------------------------------------------------
module frt_ctrl import frt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [1:0] op,
	input  frt_stat_t stat,
	output frt_cmd_t  cmd,
	output logic      busy,
	output logic      done,
	output logic      rej
);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_SCAN, S_EVICT, S_NEW, S_PAY, S_WINIT, S_WALK, S_FIN,
		S_RD, S_RD2, S_REJ, S_OUT
	} state_t;

	state_t state_q;

	always_comb begin
		unique case (state_q)
			S_IDLE:  cmd = start ? CMD_LOAD : CMD_NONE;
			S_SCAN:  cmd = stat.scan_done ? CMD_NONE : CMD_SCAN;
			S_EVICT: cmd = stat.evict_done ? CMD_HDR_NEW : CMD_EVICT;
			S_NEW:   cmd = CMD_HDR_OLD;
			S_PAY:   cmd = CMD_WRITE;
			S_WINIT: cmd = CMD_WALK_INIT;
			S_WALK:  cmd = stat.walk_done ? CMD_CLEAR : CMD_WALK;
			S_RD2:   cmd = CMD_RESP;
			S_FIN:   cmd = CMD_CLEAR;
			S_REJ:   cmd = CMD_REJECT;
			default: cmd = CMD_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			rej     <= 1'b0;
		end else begin
			done <= 1'b0;
			rej  <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_DEC;
				S_DEC: begin
					unique case (op)
						OP_HEADER:  state_q <= stat.hdr_ok ? S_SCAN : S_REJ;
						OP_PAYLOAD: state_q <= S_PAY;
						OP_READ:    state_q <= stat.read_ok ? S_RD : S_REJ;
						default:    state_q <= stat.clear_ok ? S_FIN : S_REJ;
					endcase
				end
				S_SCAN: if (stat.scan_done) begin
					if (stat.found) state_q <= stat.match_ok ? S_NEW : S_REJ;
					else state_q <= stat.new_ok ? S_EVICT : S_REJ;
				end
				S_EVICT: if (stat.evict_done) state_q <= S_OUT;
				S_NEW:   state_q <= S_OUT;
				S_PAY:   state_q <= (stat.pay_ok && stat.last) ? S_WINIT : S_OUT;
				S_WINIT: state_q <= S_WALK;
				S_WALK:  if (stat.walk_done) state_q <= S_OUT;
				S_FIN:   state_q <= S_OUT;
				S_RD:    state_q <= S_RD2;
				S_RD2:   state_q <= S_OUT;
				S_REJ: begin
					rej <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
